/* hw/rtl/vst_pkg.sv */
// Shared definitions for the version slot table: request kinds, status codes,
// default sizes. No dependencies.
`timescale 1ns / 1ps

package vst_pkg;

  localparam int unsigned SlotsPerPageDef = 256;
  localparam int unsigned PageCountDef    = 16;
  localparam int unsigned WordBits        = 64;

  // request kinds
  localparam logic [3:0] REQ_ACQUIRE    = 4'd0;
  localparam logic [3:0] REQ_MARK       = 4'd1;
  localparam logic [3:0] REQ_FREE       = 4'd2;
  localparam logic [3:0] REQ_QUERY_SLOT = 4'd3;
  localparam logic [3:0] REQ_QUERY_FULL = 4'd4;
  localparam logic [3:0] REQ_XMIN       = 4'd5;
  localparam logic [3:0] REQ_XMAX       = 4'd6;
  localparam logic [3:0] REQ_SEGOFF     = 4'd7;
  localparam logic [3:0] REQ_HINT_WR    = 4'd8;
  localparam logic [3:0] REQ_HINT_OR    = 4'd9;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_FREE   = 2'd1;
  localparam logic [1:0] STAT_OCCUPIED  = 2'd2;
  localparam logic [1:0] STAT_NOT_OCC   = 2'd3;

  // result of searching one occupancy word for a free slot
  typedef struct packed {
    logic        found;
    logic [5:0]  idx;
    logic [63:0] set_word;
  } free_search_t;

endpackage

/* hw/rtl/vst_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module vst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/vst_free_find.sv */
// Lowest-free-slot search over one 64-bit occupancy word.
// Depends on vst_pkg.
`timescale 1ns / 1ps

module vst_free_find
  import vst_pkg::*;
(
  input  logic [63:0]  word_i,
  input  logic [63:0]  need_i,   // slots that exist in this word
  output free_search_t res_o
);

  logic [63:0] free_bits;

  always_comb begin
    free_bits        = ~word_i & need_i;
    res_o.found      = |free_bits;
    res_o.idx        = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        res_o.idx = 6'(i);
      end
    end
    res_o.set_word   = word_i | (64'd1 << res_o.idx);
  end

endmodule

/* hw/rtl/version_slot_table.sv */
// Version slot table top level: occupancy bitmap RAM with a word sequencer,
// per-slot entry RAMs, registered result word. Depends on vst_pkg, vst_ram,
// vst_free_find.
// A request is accepted in StIdle; StScan then walks the page's occupancy words,
// WORDS = ceil(SLOTS/64) (4 at 256 slots), and StFinish loads the result word;
// rejected kinds or pages go straight to StFinish. A new request is taken only in
// StIdle, once the last result word is loaded; the walk reads one word per
// cycle through the occupancy RAM port. Result stalls hold the sequencer in
// its last state. Reset: control clears at once, then a clearing pass zeroes
// all PAGE_COUNT*WORDS bitmap words (64 by default) while s_axis_tready stays low.
`timescale 1ns / 1ps

module version_slot_table
  import vst_pkg::*;
#(
  parameter int unsigned SlotsPerPage = SlotsPerPageDef,
  parameter int unsigned PageCount    = PageCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[3:0], page_index[7:4], slot_offset[15:8], write_value[47:16]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // granted_slot[7:0], slot_occupied[8], page_full[9], status[11:10], zero pad
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned Words    = (SlotsPerPage + WordBits - 1) / WordBits;
  localparam int unsigned OccDepth = PageCount * Words;
  localparam int unsigned OccAw    = (OccDepth > 1) ? $clog2(OccDepth) : 1;
  localparam int unsigned EntDepth = PageCount * SlotsPerPage;
  localparam int unsigned EntAw    = (EntDepth > 1) ? $clog2(EntDepth) : 1;
  localparam int unsigned WidxW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned LastBits = SlotsPerPage - (Words - 1) * WordBits;
  localparam logic [63:0] LastMask = (LastBits == WordBits) ? {64{1'b1}}
                                     : ((64'd1 << LastBits) - 64'd1);

  typedef enum logic [1:0] {StClear, StIdle, StScan, StFinish} state_e;

  state_e              state_q, state_d;
  logic [OccAw-1:0]    clr_q, clr_d;
  logic [3:0]          kind_q, kind_d;
  logic [7:0]          slot_q, slot_d;
  logic [31:0]         val_q, val_d;
  logic [OccAw-1:0]    base_q, base_d;
  logic [EntAw-1:0]    ent_q, ent_d;
  logic [WidxW-1:0]    w_q, w_d;
  logic                found_q, found_d;
  logic [7:0]          granted_q, granted_d;
  logic                occ_q, occ_d;
  logic                full_q, full_d;
  logic [1:0]          status_q, status_d;
  logic                ent_ok_q, ent_ok_d;
  logic                out_valid_q, out_valid_d;
  logic [15:0]         out_data_q, out_data_d;

  logic [3:0]          in_kind;
  logic [3:0]          in_page;
  logic [7:0]          in_slot;
  logic                in_ok;
  logic                accept;
  logic [OccAw-1:0]    in_base;
  logic [EntAw-1:0]    in_ent;

  logic                occ_we, occ_re;
  logic [OccAw-1:0]    occ_waddr, occ_raddr;
  logic [63:0]         occ_wdata, occ_rdata;
  logic [63:0]         need;
  logic                last_word;
  logic                slot_in_range;
  logic                tgt_kind;
  logic                tgt_hit;
  logic                bit_was;
  logic [63:0]         new_word;
  logic [31:0]         grant_full;
  free_search_t        srch;

  logic                leave;
  logic                xmin_we, xmax_we, seg_we, hint_we;
  logic [15:0]         hint_rdata, hint_wdata;

  assign in_kind = s_axis_tdata[3:0];
  assign in_page = s_axis_tdata[7:4];
  assign in_slot = s_axis_tdata[15:8];
  assign in_ok   = (in_kind <= REQ_HINT_OR) && (32'(in_page) < PageCount);
  assign in_base = OccAw'(in_page) * OccAw'(Words);
  assign in_ent  = EntAw'(in_page) * EntAw'(SlotsPerPage) + EntAw'(in_slot);

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign leave         = (state_q == StFinish) && (!out_valid_q || m_axis_tready);

  assign last_word     = (w_q == WidxW'(Words - 1));
  assign need          = last_word ? LastMask : {64{1'b1}};
  assign slot_in_range = (32'(slot_q) < SlotsPerPage);
  assign tgt_kind      = (kind_q != REQ_ACQUIRE) && (kind_q != REQ_QUERY_FULL);
  assign tgt_hit       = tgt_kind && slot_in_range && (32'(w_q) == 32'(slot_q[7:6]));
  assign bit_was       = occ_rdata[slot_q[5:0]];
  assign grant_full    = (32'(w_q) << 6) | 32'(srch.idx);

  vst_free_find u_find (
    .word_i (occ_rdata),
    .need_i (need),
    .res_o  (srch)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    kind_d      = kind_q;
    slot_d      = slot_q;
    val_d       = val_q;
    base_d      = base_q;
    ent_d       = ent_q;
    w_d         = w_q;
    found_d     = found_q;
    granted_d   = granted_q;
    occ_d       = occ_q;
    full_d      = full_q;
    status_d    = status_q;
    ent_ok_d    = ent_ok_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    occ_we      = 1'b0;
    occ_waddr   = base_q + OccAw'(w_q);
    occ_wdata   = '0;
    occ_re      = 1'b0;
    occ_raddr   = base_q + OccAw'(32'(w_q) + 32'd1);
    new_word    = occ_rdata;

    case (state_q)
      StClear: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        if (clr_q == OccAw'(OccDepth - 1)) begin
          state_d = StIdle;
        end else begin
          clr_d = clr_q + OccAw'(1);
        end
      end
      StIdle: begin
        if (accept) begin
          kind_d    = in_kind;
          slot_d    = in_slot;
          val_d     = s_axis_tdata[47:16];
          base_d    = in_base;
          ent_d     = in_ent;
          w_d       = '0;
          found_d   = 1'b0;
          granted_d = '0;
          occ_d     = 1'b0;
          status_d  = STAT_OK;
          ent_ok_d  = 1'b0;
          if (in_ok) begin
            full_d    = 1'b1;
            occ_re    = 1'b1;
            occ_raddr = in_base;
            state_d   = StScan;
          end else begin
            full_d  = 1'b0;
            state_d = StFinish;
          end
        end
      end
      StScan: begin
        // data for word w_q is on the RAM output; write back any change, fetch the next unless last
        if (kind_q == REQ_ACQUIRE) begin
          if (!found_q && srch.found) begin
            new_word  = srch.set_word;
            occ_we    = 1'b1;
            found_d   = 1'b1;
            granted_d = grant_full[7:0];
          end
          if (last_word && !found_q && !srch.found) begin
            status_d = STAT_NO_FREE;
          end
        end else if (tgt_hit) begin
          occ_d = bit_was;
          case (kind_q)
            REQ_MARK: begin
              if (bit_was) begin
                status_d = STAT_OCCUPIED;
              end else begin
                new_word = occ_rdata | (64'd1 << slot_q[5:0]);
                occ_we   = 1'b1;
              end
            end
            REQ_FREE: begin
              if (!bit_was) begin
                status_d = STAT_NOT_OCC;
              end else begin
                new_word = occ_rdata & ~(64'd1 << slot_q[5:0]);
                occ_we   = 1'b1;
              end
            end
            REQ_XMIN, REQ_XMAX, REQ_SEGOFF, REQ_HINT_WR, REQ_HINT_OR: begin
              if (!bit_was) begin
                status_d = STAT_NOT_OCC;
              end else begin
                ent_ok_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        occ_wdata = new_word;
        full_d    = full_q && ((new_word & need) == need);
        if (last_word) begin
          state_d = StFinish;
        end else begin
          occ_re = 1'b1;
          w_d    = w_q + WidxW'(1);
        end
      end
      StFinish: begin
        if (leave) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'b0, status_q, full_q, occ_q, granted_q};
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      ent_ok_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      ent_ok_q    <= ent_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    slot_q     <= slot_d;
    val_q      <= val_d;
    base_q     <= base_d;
    ent_q      <= ent_d;
    w_q        <= w_d;
    found_q    <= found_d;
    granted_q  <= granted_d;
    occ_q      <= occ_d;
    full_q     <= full_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

  vst_ram #(.Width(64), .Depth(OccDepth)) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .re_i    (occ_re),
    .raddr_i (occ_raddr),
    .rdata_o (occ_rdata)
  );

  // entry updates land as the result word leaves
  assign xmin_we    = leave && ent_ok_q && (kind_q == REQ_XMIN);
  assign xmax_we    = leave && ent_ok_q && (kind_q == REQ_XMAX);
  assign seg_we     = leave && ent_ok_q && (kind_q == REQ_SEGOFF);
  assign hint_we    = leave && ent_ok_q &&
                      ((kind_q == REQ_HINT_WR) || (kind_q == REQ_HINT_OR));
  assign hint_wdata = (kind_q == REQ_HINT_WR) ? val_q[15:0] : (hint_rdata | val_q[15:0]);

  vst_ram #(.Width(32), .Depth(EntDepth)) u_xmin_ram (
    .clk_i   (clk_i),
    .we_i    (xmin_we),
    .waddr_i (ent_q),
    .wdata_i (val_q),
    .re_i    (1'b0),
    .raddr_i (ent_q),
    .rdata_o ()
  );

  vst_ram #(.Width(32), .Depth(EntDepth)) u_xmax_ram (
    .clk_i   (clk_i),
    .we_i    (xmax_we),
    .waddr_i (ent_q),
    .wdata_i (val_q),
    .re_i    (1'b0),
    .raddr_i (ent_q),
    .rdata_o ()
  );

  vst_ram #(.Width(32), .Depth(EntDepth)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (ent_q),
    .wdata_i (val_q),
    .re_i    (1'b0),
    .raddr_i (ent_q),
    .rdata_o ()
  );

  // hint bits read at accept and held for the OR update
  vst_ram #(.Width(16), .Depth(EntDepth)) u_hint_ram (
    .clk_i   (clk_i),
    .we_i    (hint_we),
    .waddr_i (ent_q),
    .wdata_i (hint_wdata),
    .re_i    (accept),
    .raddr_i (in_ent),
    .rdata_o (hint_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* verif/version_slot_table_tb.sv */
// Testbench for version_slot_table: drives request words, predicts every result word
// with its own bitmap allocator model and checks them in order. Depends on vst_pkg.
`timescale 1ns / 1ps

module version_slot_table_tb;
  import vst_pkg::*;

  localparam int unsigned Pages      = PageCountDef;
  localparam int unsigned Slots      = SlotsPerPageDef;
  localparam int unsigned RandItems  = 1850;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned TailCycles = 16;
  localparam logic [3:0]  REQ_CODE_MAX = 4'hF;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_mode_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  page;
    logic [7:0]  slot;
    logic [31:0] value;
  } slot_req_t;

  typedef struct packed {
    logic [3:0] pad;
    logic [1:0] status;
    logic       full;
    logic       occ;
    logic [7:0] granted;
  } slot_rsp_t;

  // Allocator model plus the queue of result words it predicts.
  class slot_table_scoreboard;
    bit          occ_map [Pages][Slots];
    bit          hint_set [Pages][Slots];
    slot_rsp_t   expected_rsp[$];
    int unsigned mismatches = 0;
    int unsigned requests = 0;
    int unsigned full_words = 0;
    int unsigned status_seen[4];

    function int unsigned pending();
      return expected_rsp.size();
    endfunction

    function bit page_full(int unsigned pg);
      for (int unsigned i = 0; i < Slots; i++) begin
        if (!occ_map[pg][i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(slot_req_t r);
      slot_rsp_t rsp;
      bit        was;
      bit        found;
      rsp = '0;
      requests++;
      if (r.kind <= REQ_HINT_OR && r.page < Pages) begin
        if (r.kind == REQ_ACQUIRE) begin
          found = 1'b0;
          for (int unsigned i = 0; i < Slots && !found; i++) begin
            if (!occ_map[r.page][i]) begin
              occ_map[r.page][i] = 1'b1;
              rsp.granted = 8'(i);
              found = 1'b1;
            end
          end
          if (!found) rsp.status = STAT_NO_FREE;
        end else if (r.kind != REQ_QUERY_FULL && r.slot < Slots) begin
          was = occ_map[r.page][r.slot];
          rsp.occ = was;
          case (r.kind)
            REQ_MARK: begin
              if (was) rsp.status = STAT_OCCUPIED;
              else occ_map[r.page][r.slot] = 1'b1;
            end
            REQ_FREE: begin
              if (!was) rsp.status = STAT_NOT_OCC;
              else occ_map[r.page][r.slot] = 1'b0;
            end
            REQ_QUERY_SLOT: ;
            default: begin
              // entry updates only land on occupied slots
              if (!was) rsp.status = STAT_NOT_OCC;
              else if (r.kind == REQ_HINT_WR) hint_set[r.page][r.slot] = 1'b1;
            end
          endcase
        end
        rsp.full = page_full(r.page);
      end
      if (rsp.full) full_words++;
      status_seen[rsp.status]++;
      expected_rsp.push_back(rsp);
    endfunction

    function void check_result(logic [15:0] word);
      slot_rsp_t exp_rsp;
      slot_rsp_t act;
      act = word;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, word);
        mismatches++;
        return;
      end
      exp_rsp = expected_rsp.pop_front();
      if (act.granted !== exp_rsp.granted) begin
        $display("%0t: granted_slot expected %0d actual %0d", $time, exp_rsp.granted,
                 act.granted);
        mismatches++;
      end
      if (act.occ !== exp_rsp.occ) begin
        $display("%0t: slot_occupied expected %0b actual %0b", $time, exp_rsp.occ, act.occ);
        mismatches++;
      end
      if (act.full !== exp_rsp.full) begin
        $display("%0t: page_full expected %0b actual %0b", $time, exp_rsp.full, act.full);
        mismatches++;
      end
      if (act.status !== exp_rsp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status, act.status);
        mismatches++;
      end
      if (act.pad !== exp_rsp.pad) begin
        $display("%0t: pad bits expected %h actual %h", $time, exp_rsp.pad, act.pad);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  slot_table_scoreboard sb;
  int unsigned src_gap_max = 8;
  int unsigned sink_stall_max = 8;
  int unsigned idle_cycles = 0;

  version_slot_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Call at a rising edge; returns at the edge that accepts the word.
  task automatic send_request(slot_req_t r);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.value, r.slot, r.page, r.kind};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(r);
  endtask

  task automatic send_fields(logic [3:0] kind, logic [3:0] pg, logic [7:0] slot,
                             logic [31:0] value);
    slot_req_t r;
    r = '{kind: kind, page: pg, slot: slot, value: value};
    send_request(r);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Random slot on the page that is occupied (or hint-written); -1 if none.
  function automatic int find_slot(int unsigned pg, bit need_hint);
    int unsigned start;
    int unsigned s;
    start = $urandom_range(0, Slots - 1);
    for (int unsigned i = 0; i < Slots; i++) begin
      s = (start + i) % Slots;
      if (need_hint ? sb.hint_set[pg][s] : sb.occ_map[pg][s]) return int'(s);
    end
    return -1;
  endfunction

  function automatic logic [7:0] occupied_or_any(int unsigned pg);
    int s;
    s = find_slot(pg, 1'b0);
    return (s < 0) ? 8'($urandom_range(0, Slots - 1)) : 8'(s);
  endfunction

  function automatic slot_req_t build_request(seg_mode_e mode, logic [3:0] pg);
    slot_req_t   r;
    int unsigned pick;
    int          hs;
    r.page  = pg;
    r.value = $urandom();
    r.slot  = 8'($urandom_range(0, Slots - 1));
    pick    = $urandom_range(0, 19);
    case (mode)
      SEG_FILL: begin
        if (pick < 17) r.kind = REQ_ACQUIRE;
        else if (pick == 17) r.kind = REQ_MARK;
        else if (pick == 18) r.kind = REQ_QUERY_FULL;
        else begin
          r.kind = REQ_XMIN + 4'($urandom_range(0, 4));
          r.slot = occupied_or_any(pg);
        end
      end
      SEG_DRAIN: begin
        if (pick < 14) begin
          r.kind = REQ_FREE;
          r.slot = occupied_or_any(pg);
        end else if (pick < 16) r.kind = REQ_FREE;
        else if (pick == 16) r.kind = REQ_QUERY_SLOT;
        else if (pick == 17) r.kind = REQ_ACQUIRE;
        else if (pick == 18) r.kind = REQ_QUERY_FULL;
        else r.kind = REQ_XMIN + 4'($urandom_range(0, 4));
      end
      default: begin
        if (pick == 0) r.kind = 4'($urandom_range(REQ_HINT_OR + 1, REQ_CODE_MAX));
        else r.kind = 4'($urandom_range(REQ_ACQUIRE, REQ_HINT_OR));
        if ($urandom_range(0, 1) == 1) r.slot = occupied_or_any(pg);
      end
    endcase
    // hint OR only on entries whose hint bits were written before
    if (r.kind == REQ_HINT_OR && !sb.hint_set[pg][r.slot]) begin
      hs = find_slot(pg, 1'b1);
      if (hs < 0) r.kind = REQ_HINT_WR;
      else r.slot = 8'(hs);
    end
    return r;
  endfunction

  // Result side: random stall before each word.
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, sink_stall_max);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    seg_mode_e   mode;
    logic [3:0]  pg;
    logic [3:0]  hot_pg;
    int unsigned seg_len;
    int unsigned sent;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corners of every request kind and the occupied, not-occupied and unknown-kind faults
    send_fields(REQ_QUERY_FULL, 4'd3, 8'd0, 32'h0);
    send_fields(REQ_ACQUIRE, 4'd0, 8'd0, 32'h0);
    send_fields(REQ_ACQUIRE, 4'd0, 8'd0, 32'hFFFF_FFFF);
    send_fields(REQ_MARK, 4'd15, 8'd255, 32'h0);
    send_fields(REQ_MARK, 4'd15, 8'd255, 32'h0);
    send_fields(REQ_QUERY_SLOT, 4'd15, 8'd255, 32'h0);
    send_fields(REQ_QUERY_SLOT, 4'd15, 8'd254, 32'h0);
    send_fields(REQ_FREE, 4'd15, 8'd254, 32'h0);
    send_fields(REQ_XMIN, 4'd15, 8'd255, 32'hFFFF_FFFF);
    send_fields(REQ_XMAX, 4'd15, 8'd255, 32'h0);
    send_fields(REQ_SEGOFF, 4'd15, 8'd255, 32'hA5A5_5A5A);
    send_fields(REQ_HINT_WR, 4'd15, 8'd255, 32'hFFFF_0000);
    send_fields(REQ_HINT_OR, 4'd15, 8'd255, 32'h0000_FFFF);
    send_fields(REQ_XMIN, 4'd15, 8'd0, 32'h1234_5678);
    send_fields(REQ_HINT_WR, 4'd15, 8'd0, 32'hFFFF_FFFF);
    send_fields(REQ_FREE, 4'd15, 8'd255, 32'h0);
    // hint OR on a slot freed after its hint bits were written
    send_fields(REQ_HINT_OR, 4'd15, 8'd255, 32'h0000_00FF);
    send_fields(REQ_MARK, 4'd1, 8'd0, 32'h0);
    send_fields(REQ_ACQUIRE, 4'd1, 8'd0, 32'h0);
    for (int k = REQ_HINT_OR + 1; k <= REQ_CODE_MAX; k++) begin
      send_fields(4'(k), 4'($urandom_range(0, Pages - 1)), 8'($urandom_range(0, Slots - 1)),
                  $urandom());
    end
    wait_for_results();
    @(posedge clk_i);

    // random: segments aimed at one page, the first one fills it up
    sent = 0;
    hot_pg = 4'($urandom_range(0, Pages - 1));
    while (sent < RandItems) begin
      if (sent == 0) begin
        mode = SEG_FILL;
      end else begin
        mode = seg_mode_e'($urandom_range(SEG_FILL, SEG_MIXED));
      end
      if (mode == SEG_FILL) hot_pg = 4'($urandom_range(0, Pages - 1));
      pg = ($urandom_range(0, 2) != 0) ? hot_pg : 4'($urandom_range(0, Pages - 1));
      seg_len = (mode == SEG_FILL) ? 320 : $urandom_range(30, 120);
      src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 8;
      sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      for (int unsigned n = 0; n < seg_len && sent < RandItems; n++) begin
        send_request(build_request(mode, pg));
        sent++;
      end
      if (sent == seg_len || $urandom_range(0, 3) == 0) begin
        wait_for_results();
        @(posedge clk_i);
      end
    end

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    $display("Checked %0d requests; %0d results reported a full page.", sb.requests,
             sb.full_words);
    $display("Status counts: ok %0d, no free %0d, occupied %0d, not occupied %0d",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_NO_FREE],
             sb.status_seen[STAT_OCCUPIED], sb.status_seen[STAT_NOT_OCC]);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/vst_pkg.sv
hw/rtl/vst_ram.sv
hw/rtl/vst_free_find.sv
hw/rtl/version_slot_table.sv
verif/version_slot_table_tb.sv
